### hw/rtl/desort_pkg.sv
`default_nettype none

package desort_pkg;

    localparam int RANK_W = 6;

    // One loaded entry as it arrives on the input channel.
    typedef struct packed {
        logic [15:0] score;
        logic [31:0] name_first_four;
        logic [31:0] name_next_four;
        logic [7:0]  name_final_char;
        logic        last_entry;
    } entry_word_t;

    // One ranked entry as it leaves on the output channel.
    typedef struct packed {
        logic [RANK_W-1:0] rank_position;
        logic [15:0]       ranked_score;
        logic [31:0]       ranked_name_first;
        logic [31:0]       ranked_name_next;
        logic [7:0]        ranked_name_final;
        logic              final_rank;
    } rank_word_t;

    // One row of the entry store.
    typedef struct packed {
        logic [15:0] score;
        logic [31:0] name_first;
        logic [31:0] name_next;
        logic [7:0]  name_final;
    } store_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH_I,
        ST_TAKE_I,
        ST_CMP,
        ST_PUT_I,
        ST_EMIT_RD,
        ST_EMIT_PUT
    } sort_state_t;

endpackage

`default_nettype wire

### hw/rtl/descending_exchange_sort_engine.sv
`default_nettype none

// Descending exchange sort engine. Score entries (16-bit score plus a
// nine-character name) are taken one word per cycle while entry_stall is
// low and stored in arrival order in a single-port-write, registered-read
// entry store of ENTRIES rows; entries that arrive once the store is full
// are dropped. The word marked last_entry (stored first if there is room)
// starts the sort: for each position i the row is held in a working
// register while every later row j is read and compared, one row per
// cycle, swapping on score[i] < score[j]. Ties come out in the order this
// exchange procedure gives. The ranking then streams out, rank 0 first,
// with final_rank on the last word; each word takes one store read and one
// output register load, and the next read waits while the output register
// holds a stalled word. entry_stall is high from the last entry until the
// final ranked word has been placed on the output; the next set may load
// while that final word still waits to be taken.
module descending_exchange_sort_engine #(
    parameter int ENTRIES = 64
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      entry_valid,
    output logic                     entry_stall,
    input  desort_pkg::entry_word_t  entry_data,
    output logic                     rank_valid,
    input  wire                      rank_stall,
    output desort_pkg::rank_word_t   rank_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = desort_pkg::RANK_W;

    // Entry store
    desort_pkg::store_entry_t mem [ENTRIES];

    desort_pkg::sort_state_t  state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            i_reg, i_next;
    logic [AW-1:0]            j_reg, j_next;
    logic [AW-1:0]            k_reg, k_next;
    desort_pkg::store_entry_t cur_reg, cur_next;
    desort_pkg::store_entry_t rd_reg;
    logic                     out_valid_reg, out_valid_next;
    desort_pkg::rank_word_t   out_reg, out_next;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    desort_pkg::store_entry_t mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic                     slot_free;
    logic                     has_room;
    logic [CW-1:0]            load_len;
    desort_pkg::store_entry_t in_row;

    assign entry_stall = (state_reg != desort_pkg::ST_LOAD);
    assign rank_valid  = out_valid_reg;
    assign rank_data   = out_reg;

    // Output register is free when empty or being taken this cycle.
    assign slot_free = !out_valid_reg || !rank_stall;
    assign has_room  = (count_reg < CW'(ENTRIES));
    assign load_len  = has_room ? count_reg + 1'b1 : count_reg;

    assign in_row.score      = entry_data.score;
    assign in_row.name_first = entry_data.name_first_four;
    assign in_row.name_next  = entry_data.name_next_four;
    assign in_row.name_final = entry_data.name_final_char;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && rank_stall;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = in_row;
        mem_raddr      = j_reg;

        unique case (state_reg)
            desort_pkg::ST_LOAD:
            begin
                if (entry_valid)
                begin
                    // Store when there is room; drop otherwise.
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (entry_data.last_entry)
                    begin
                        i_next = '0;
                        k_next = '0;
                        if (load_len >= CW'(2))
                            state_next = desort_pkg::ST_FETCH_I;
                        else
                            state_next = desort_pkg::ST_EMIT_RD;
                    end
                end
            end

            desort_pkg::ST_FETCH_I:
            begin
                mem_raddr  = i_reg;
                state_next = desort_pkg::ST_TAKE_I;
            end

            desort_pkg::ST_TAKE_I:
            begin
                // Hold row i in the working register; start the j sweep.
                cur_next   = rd_reg;
                mem_raddr  = i_reg + 1'b1;
                j_next     = i_reg + 1'b1;
                state_next = desort_pkg::ST_CMP;
            end

            desort_pkg::ST_CMP:
            begin
                if (cur_reg.score < rd_reg.score)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = cur_reg;
                    cur_next  = rd_reg;
                end
                if ((CW'(j_reg) + 1'b1) < count_reg)
                begin
                    j_next    = j_reg + 1'b1;
                    mem_raddr = j_reg + 1'b1;
                end
                else
                    state_next = desort_pkg::ST_PUT_I;
            end

            desort_pkg::ST_PUT_I:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                mem_wdata = cur_reg;
                i_next    = i_reg + 1'b1;
                if ((CW'(i_reg) + CW'(2)) < count_reg)
                    state_next = desort_pkg::ST_FETCH_I;
                else
                    state_next = desort_pkg::ST_EMIT_RD;
            end

            desort_pkg::ST_EMIT_RD:
            begin
                if (slot_free)
                begin
                    mem_raddr  = k_reg;
                    state_next = desort_pkg::ST_EMIT_PUT;
                end
            end

            desort_pkg::ST_EMIT_PUT:
            begin
                out_valid_next             = 1'b1;
                out_next.rank_position     = RW'(k_reg);
                out_next.ranked_score      = rd_reg.score;
                out_next.ranked_name_first = rd_reg.name_first;
                out_next.ranked_name_next  = rd_reg.name_next;
                out_next.ranked_name_final = rd_reg.name_final;
                out_next.final_rank        = ((CW'(k_reg) + 1'b1) == count_reg);
                if ((CW'(k_reg) + 1'b1) == count_reg)
                begin
                    count_next = '0;
                    state_next = desort_pkg::ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = desort_pkg::ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = desort_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= desort_pkg::ST_LOAD;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // Store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/desort_checker.sv
`default_nettype none

module desort_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     entry_valid,
    input wire                     entry_stall,
    input desort_pkg::entry_word_t entry_data,
    input wire                     rank_valid,
    input wire                     rank_stall,
    input desort_pkg::rank_word_t  rank_data
);

    logic [desort_pkg::RANK_W-1:0] exp_pos_reg;
    logic [15:0]                   prev_score_reg;
    logic                          busy_reg;
    logic                          rank_take;

    assign rank_take = rank_valid && !rank_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pos_reg    <= '0;
            prev_score_reg <= '0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            if (rank_take)
            begin
                prev_score_reg <= rank_data.ranked_score;
                if (rank_data.final_rank)
                    exp_pos_reg <= '0;
                else
                    exp_pos_reg <= exp_pos_reg + 1'b1;
            end
            if (rank_valid && rank_data.final_rank)
                busy_reg <= 1'b0;
            else if (entry_valid && !entry_stall && entry_data.last_entry)
                busy_reg <= 1'b1;
        end
    end

    // Hold a stalled ranked word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rank_valid && rank_stall |=> rank_valid && $stable(rank_data))
        else $error("ranked word changed while stalled");

    // Ranks count up from zero within each set.
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rank_valid |-> rank_data.rank_position == exp_pos_reg)
        else $error("rank position out of sequence");

    // Scores never rise along a ranking.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        rank_valid && exp_pos_reg != '0 |->
            rank_data.ranked_score <= prev_score_reg)
        else $error("ranking not descending");

    // No entry taken while a set is sorting or streaming.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !(rank_valid && rank_data.final_rank) |-> entry_stall)
        else $error("entry accepted during sort");

endmodule

bind descending_exchange_sort_engine desort_checker u_desort_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (entry_valid),
    .entry_stall (entry_stall),
    .entry_data  (entry_data),
    .rank_valid  (rank_valid),
    .rank_stall  (rank_stall),
    .rank_data   (rank_data)
);

`default_nettype wire
